@@ rtl/text_console_writer_defines.svh @@
// Assertion macros shared by the console writer checker.
// Depends on nothing; included by the checker file by bare name.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw: same-cycle check failed");

`endif

@@ rtl/tcw_pkg.sv @@
// Package for the text console writer: word types, character codes and defaults.
// Depends on nothing; used by the top level.
`default_nettype none
package tcw_pkg;

  // Fixed field widths
  localparam int IDX_W = 11;

  // Default grid size
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Item kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Character codes
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7F;

  // Attributes and cell words {char, attr}
  localparam logic [7:0]  BLANK_ATTR = 8'h07;
  localparam logic [15:0] BLANK_CELL = {CH_NUL, BLANK_ATTR};
  localparam logic [15:0] SPACE_CELL = {CH_SPACE, BLANK_ATTR};

  typedef struct packed {
    logic             kind;
    logic [7:0]       char_code;
    logic [7:0]       color;
    logic [IDX_W-1:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] cursor_pos;
    logic             scrolled;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
  } rsp_t;

endpackage
`default_nettype wire

@@ rtl/text_console_writer.sv @@
// A put word runs execute; a read word runs execute, then read data; a put with scroll
// runs execute, scroll, then blank. Throughput: one word at a time; busy stays high
// until the result strobe cycle. A scroll copies each cell up one row through the
// single-port-pair cell memory. Reset: cursor to 0, then a clearing pass writes every
// cell to char 0, attribute 0x07 while busy is high. The receiver cannot stall results.
`default_nettype none
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire tcw_pkg::cmd_t cmd,
  output logic               busy,
  output logic               done,
  output tcw_pkg::rsp_t      rsp
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS + 1);

  localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCROLL_LAST = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] BLANK_FIRST = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
  localparam logic [AW:0]   COLS_X      = (AW + 1)'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);
  localparam logic [RW-1:0] ROW_END     = RW'(ROWS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RDATA  = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_BLANK  = 3'd5;

  // Cell memory, {char, attr} per cell
  logic [15:0] mem [CELLS];
  logic [15:0] rd_data;

  logic [2:0]    state;
  logic [AW-1:0] cnt;
  logic          wr_pend;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] cursor;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          rd_ok;
  cmd_t          item;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic [AW:0]   cur_ext;
  logic [AW:0]   cur_adv;
  logic [AW:0]   cur_fin;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_adv;
  logic [RW-1:0] row_next;
  logic [AW-1:0] cursor_next;
  logic          put_we;
  logic [AW-1:0] put_addr;
  logic [15:0]   put_data;
  logic          need_scroll;
  logic          idx_ok;
  logic [7:0]    put_attr;

  assign busy = (state != S_IDLE);

  // Decode a put word against the current cursor
  assign cur_ext  = {1'b0, cursor};
  assign idx_ok   = (int'(item.cell_index) < CELLS);
  assign put_attr = (item.char_code >= CH_PRINT_LO && item.char_code <= CH_PRINT_HI) ?
                    item.color : BLANK_ATTR;

  always_comb begin
    cur_adv  = cur_ext;
    col_next = col;
    row_adv  = row;
    put_we   = 1'b0;
    put_addr = cursor;
    put_data = SPACE_CELL;
    case (item.char_code)
      CH_BS: begin
        if (cursor != '0) begin
          cur_adv = cur_ext - (AW + 1)'(1);
          if (col == '0) begin
            col_next = COL_LAST;
            row_adv  = row - RW'(1);
          end else begin
            col_next = col - CW'(1);
          end
        end
        put_we   = 1'b1;
        put_addr = cur_adv[AW-1:0];
        put_data = SPACE_CELL;
      end
      CH_NUL: begin
        cur_adv = cur_ext;
      end
      CH_LF: begin
        cur_adv  = cur_ext - (AW + 1)'(col) + COLS_X;
        col_next = '0;
        row_adv  = row + RW'(1);
      end
      default: begin
        put_we   = 1'b1;
        put_addr = cursor;
        put_data = {item.char_code, put_attr};
        cur_adv  = cur_ext + (AW + 1)'(1);
        if (col == COL_LAST) begin
          col_next = '0;
          row_adv  = row + RW'(1);
        end else begin
          col_next = col + CW'(1);
        end
      end
    endcase
    need_scroll = (row_adv == ROW_END);
    cur_fin     = need_scroll ? (cur_adv - COLS_X) : cur_adv;
    row_next    = need_scroll ? ROW_LAST : row_adv;
    cursor_next = cur_fin[AW-1:0];
  end

  // Select the memory write and read ports by phase
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = BLANK_CELL;
    mem_re    = 1'b0;
    mem_raddr = cnt + COLS_A;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_EXEC: begin
        if (item.kind == KIND_PUT) begin
          mem_we    = put_we;
          mem_waddr = put_addr;
          mem_wdata = put_data;
        end else begin
          mem_re    = idx_ok;
          mem_raddr = AW'(item.cell_index);
        end
      end
      S_SCROLL, S_BLANK: begin
        if (wr_pend) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr;
          mem_wdata = rd_data;
        end else if (state == S_BLANK) begin
          mem_we = 1'b1;
        end
        mem_re = (state == S_SCROLL);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Cell memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      item <= cmd;
    end
    if (state == S_SCROLL) begin
      wr_addr <= cnt;
    end
    if (state == S_EXEC && item.kind == KIND_READ) begin
      rd_ok <= idx_ok;
    end
    if (state == S_EXEC && item.kind == KIND_PUT) begin
      rsp <= '{cursor_pos: IDX_W'(cursor_next), scrolled: need_scroll,
               cell_char: 8'h00, cell_attr: 8'h00};
    end else if (state == S_RDATA) begin
      rsp <= '{cursor_pos: IDX_W'(cursor), scrolled: 1'b0,
               cell_char: rd_ok ? rd_data[15:8] : 8'h00,
               cell_attr: rd_ok ? rd_data[7:0] : 8'h00};
    end
  end

  // Sequencer: clear, execute, read, scroll, blank
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      wr_pend <= 1'b0;
      cursor  <= '0;
      col     <= '0;
      row     <= '0;
      done    <= 1'b0;
    end else begin
      // Strobe when a word finishes; a copied cell is written in the cycle after its read
      done    <= (state == S_RDATA) ||
                 (state == S_EXEC && item.kind == KIND_PUT && !need_scroll) ||
                 (state == S_BLANK && !wr_pend && cnt == LAST_CELL);
      wr_pend <= (state == S_SCROLL);
      case (state)
        S_CLEAR: begin
          if (cnt == LAST_CELL) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (item.kind == KIND_READ) begin
            state <= S_RDATA;
          end else begin
            cursor <= cursor_next;
            col    <= col_next;
            row    <= row_next;
            if (need_scroll) begin
              cnt   <= '0;
              state <= S_SCROLL;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_RDATA: begin
          state <= S_IDLE;
        end
        S_SCROLL: begin
          // read one row ahead, write back next cycle
          if (cnt == SCROLL_LAST) begin
            cnt   <= BLANK_FIRST;
            state <= S_BLANK;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_BLANK: begin
          // hold while the last copied cell drains
          if (!wr_pend) begin
            if (cnt == LAST_CELL) begin
              cnt   <= '0;
              state <= S_IDLE;
            end else begin
              cnt <= cnt + AW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/tcw_checker.sv @@
// Port-level checker for the text console writer, bound to the top level.
// Depends on text_console_writer_defines.svh for its assertion macros.
`default_nettype none
`include "text_console_writer_defines.svh"
module tcw_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // An accepted word keeps the block busy on the next cycle
  `TCW_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // The result strobe comes with the block ready again
  `TCW_ASSERT_SAME(a_done_ready, clk, rst, done, !busy)

  // Every strobe closes a busy stretch
  `TCW_ASSERT_SAME(a_done_after_busy, clk, rst, done, $past(busy))

  // Strobe lasts one cycle
  `TCW_ASSERT_NEXT(a_done_single, clk, rst, done, !done)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire
